FILE: src/assert_macros.svh
// assertion macros shared by the angle pipeline modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// antecedent at one edge implies consequent at the same edge
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: src/atan2_pkg.sv
// shared types and constants of the atan2 angle pipeline
`timescale 1ns / 1ps

package atan2_pkg;

	localparam int MAG_W  = 32;
	localparam int QUOT_W = 17;
	localparam int ANG_W  = 16;

	localparam logic [16:0] FIX_ONE    = 17'h10000;
	localparam logic [16:0] FIX_PI_4   = 17'd51472;
	localparam logic [14:0] POLY_C     = 15'd17892;
	localparam logic [13:0] TURN_SCALE = 14'd10430;

	localparam logic [ANG_W-1:0] ANG_ZERO    = 16'd0;
	localparam logic [ANG_W-1:0] ANG_QUARTER = 16'd16384;
	localparam logic [ANG_W-1:0] ANG_HALF    = 16'd32768;
	localparam logic [ANG_W-1:0] ANG_THREEQ  = 16'd49152;

	// information that rides alongside the division
	typedef struct packed {
		logic             special;
		logic [ANG_W-1:0] special_angle;
		logic             swap;
		logic             x_neg;
		logic             y_neg;
	} side_t;

	// state handed from one divider cell to the next
	typedef struct packed {
		logic [MAG_W-1:0]  rem;
		logic              feed;
		logic [MAG_W-1:0]  den;
		logic [QUOT_W-1:0] quot;
		side_t             side;
	} div_t;

endpackage

FILE: src/atan2_angle_approximation.sv
// top level of the four-quadrant atan2 angle pipeline
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Four-quadrant arctangent of a signed Q16.16 vector (y_value, x_value), giving a
// 16-bit angle where 65536 is a full turn. The block takes one sample per cycle while
// sample_stall is low. Each sample passes an input register for magnitudes and
// octant selection, a chain of 17 divider cells that each add one bit of the
// 17-bit ratio, and registers for the polynomial, turn scaling and quadrant fold.
// Every stage has its own valid flag, so a stall on the result side fills empty
// stages before sample_stall rises. No reset sweep is needed.
module atan2_angle_approximation (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  logic signed [atan2_pkg::MAG_W-1:0] y_value,
	input  logic signed [atan2_pkg::MAG_W-1:0] x_value,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [atan2_pkg::ANG_W-1:0]        angle
);

	localparam int NCELL = atan2_pkg::QUOT_W;

	logic                          valid_s1;
	logic                          ready_s1;
	atan2_pkg::div_t               data_s1;
	atan2_pkg::div_t               data_next;
	logic [atan2_pkg::MAG_W-1:0]   ay, ax, num, den;
	logic                          x_zero, y_zero, swap;

	logic                          cell_valid [NCELL+1];
	logic                          cell_ready [NCELL+1];
	atan2_pkg::div_t               cell_data  [NCELL+1];
	logic                          poly_ready;

	// magnitudes, octant choice and axis cases
	always_comb begin
		ay     = y_value[atan2_pkg::MAG_W-1] ? (~y_value + 32'd1) : y_value;
		ax     = x_value[atan2_pkg::MAG_W-1] ? (~x_value + 32'd1) : x_value;
		x_zero = (x_value == '0);
		y_zero = (y_value == '0);
		swap   = (ay > ax);
		num    = swap ? ax : ay;
		den    = swap ? ay : ax;
		data_next.rem  = {1'b0, num[atan2_pkg::MAG_W-1:1]};
		data_next.feed = num[0];
		data_next.den  = den;
		data_next.quot = '0;
		data_next.side.special = x_zero || y_zero;
		data_next.side.swap    = swap;
		data_next.side.x_neg   = x_value[atan2_pkg::MAG_W-1];
		data_next.side.y_neg   = y_value[atan2_pkg::MAG_W-1];
		if (x_zero) begin
			if (y_zero) begin
				data_next.side.special_angle = atan2_pkg::ANG_ZERO;
			end else begin
				data_next.side.special_angle = y_value[atan2_pkg::MAG_W-1]
					? atan2_pkg::ANG_THREEQ : atan2_pkg::ANG_QUARTER;
			end
		end else begin
			data_next.side.special_angle = x_value[atan2_pkg::MAG_W-1]
				? atan2_pkg::ANG_HALF : atan2_pkg::ANG_ZERO;
		end
	end

	// input stage
	assign ready_s1     = !valid_s1 || cell_ready[0];
	assign sample_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && ready_s1) begin
			data_s1 <= data_next;
		end
	end

	// divider chain, one quotient bit per cell
	assign cell_valid[0] = valid_s1;
	assign cell_data[0]  = data_s1;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		atan2_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (cell_valid[i]),
			.ready_o (cell_ready[i]),
			.data_i  (cell_data[i]),
			.valid_o (cell_valid[i+1]),
			.ready_i (cell_ready[i+1]),
			.data_o  (cell_data[i+1])
		);
	end

	assign cell_ready[NCELL] = poly_ready;

	// polynomial and quadrant fold
	atan2_poly u_poly (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (cell_valid[NCELL]),
		.ready_o (poly_ready),
		.ratio_i (cell_data[NCELL].quot),
		.side_i  (cell_data[NCELL].side),
		.valid_o (result_valid),
		.ready_i (!result_stall),
		.angle_o (angle)
	);

	// octant selection leaves a nonzero divisor no smaller than the dividend
	`ASSERT_IMPLIES(a_octant_order, valid_s1 && !data_s1.side.special,
		(data_s1.den != '0) && ({data_s1.rem, data_s1.feed} <= {1'b0, data_s1.den}),
		"octant selection produced bad ratio operands")

endmodule

FILE: src/atan2_div_cell.sv
// one restoring-division cell: produces one quotient bit per transfer
`timescale 1ns / 1ps
`include "assert_macros.svh"

module atan2_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_i,
	output logic              ready_o,
	input  atan2_pkg::div_t   data_i,
	output logic              valid_o,
	input  logic              ready_i,
	output atan2_pkg::div_t   data_o
);

	logic                          valid_q;
	atan2_pkg::div_t               data_q;
	logic [atan2_pkg::MAG_W:0]     trial;
	logic [atan2_pkg::MAG_W:0]     den_ext;
	logic [atan2_pkg::MAG_W:0]     diff;
	logic                          ge;
	atan2_pkg::div_t               data_next;

	// stage takes a new transfer when empty or when its content moves on
	assign ready_o = !valid_q || ready_i;

	// shift in the next dividend bit and try a subtraction
	always_comb begin
		trial   = {data_i.rem, data_i.feed};
		den_ext = {1'b0, data_i.den};
		diff    = trial - den_ext;
		ge      = (trial >= den_ext);
		data_next      = data_i;
		data_next.rem  = ge ? diff[atan2_pkg::MAG_W-1:0] : trial[atan2_pkg::MAG_W-1:0];
		data_next.feed = 1'b0;
		data_next.quot = {data_i.quot[atan2_pkg::QUOT_W-2:0], ge};
	end

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_o) begin
			valid_q <= valid_i;
		end
	end

	// payload register
	always_ff @(posedge clk) begin
		if (valid_i && ready_o) begin
			data_q <= data_next;
		end
	end

	assign valid_o = valid_q;
	assign data_o  = data_q;

	// partial remainder stays below the divisor
	`ASSERT_IMPLIES(a_rem_below_den, valid_q && !data_q.side.special,
		data_q.rem < data_q.den, "division remainder not below divisor")

endmodule

FILE: src/atan2_poly.sv
// polynomial arctangent, turn scaling and quadrant fold, three stages
`timescale 1ns / 1ps
`include "assert_macros.svh"

module atan2_poly (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid_i,
	output logic                              ready_o,
	input  logic [atan2_pkg::QUOT_W-1:0]      ratio_i,
	input  atan2_pkg::side_t                  side_i,
	output logic                              valid_o,
	input  logic                              ready_i,
	output logic [atan2_pkg::ANG_W-1:0]       angle_o
);

	logic                           valid_s1, valid_s2, valid_s3;
	logic                           ready_s1, ready_s2, ready_s3;
	logic [atan2_pkg::QUOT_W-1:0]   ratio_s1;
	logic [14:0]                    inner_s1;
	logic [16:0]                    atan_s2;
	atan2_pkg::side_t               side_s1, side_s2;
	logic [atan2_pkg::ANG_W-1:0]    angle_s3;

	logic [16:0]                    one_minus;
	logic [31:0]                    prod1;
	logic [16:0]                    coef;
	logic [33:0]                    prod2;
	logic [30:0]                    prod3;
	logic [atan2_pkg::ANG_W-1:0]    oct;
	logic [atan2_pkg::ANG_W-1:0]    fold_a;
	logic [atan2_pkg::ANG_W-1:0]    angle_next;

	// ready chain
	assign ready_s3 = !valid_s3 || ready_i;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign ready_o  = ready_s1;

	// 0.273 * (1 - r)
	always_comb begin
		one_minus = atan2_pkg::FIX_ONE - ratio_i;
		prod1     = 32'(atan2_pkg::POLY_C) * 32'(one_minus);
	end

	// r * (pi/4 + inner)
	always_comb begin
		coef  = atan2_pkg::FIX_PI_4 + 17'(inner_s1);
		prod2 = 34'(ratio_s1) * 34'(coef);
	end

	// scale to turn units, mirror about 45 degrees, fold into quadrant
	always_comb begin
		prod3  = 31'(atan_s2) * 31'(atan2_pkg::TURN_SCALE);
		oct    = 16'(prod3[29:16]);
		fold_a = side_s2.swap ? (atan2_pkg::ANG_QUARTER - oct) : oct;
		if (side_s2.special) begin
			angle_next = side_s2.special_angle;
		end else if (!side_s2.x_neg) begin
			angle_next = side_s2.y_neg ? (atan2_pkg::ANG_ZERO - fold_a) : fold_a;
		end else begin
			angle_next = side_s2.y_neg ? (atan2_pkg::ANG_HALF + fold_a)
				: (atan2_pkg::ANG_HALF - fold_a);
		end
	end

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= valid_i;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (valid_i && ready_s1) begin
			ratio_s1 <= ratio_i;
			inner_s1 <= prod1[30:16];
			side_s1  <= side_i;
		end
		if (valid_s1 && ready_s2) begin
			atan_s2  <= prod2[32:16];
			side_s2  <= side_s1;
		end
		if (valid_s2 && ready_s3) begin
			angle_s3 <= angle_next;
		end
	end

	assign valid_o = valid_s3;
	assign angle_o = angle_s3;

	// correction term never exceeds its coefficient
	`ASSERT_IMPLIES(a_inner_range, valid_s1, inner_s1 <= atan2_pkg::POLY_C,
		"polynomial correction out of range")

	// first-octant angle stays within pi/4
	`ASSERT_IMPLIES(a_atan_range, valid_s2 && !side_s2.special,
		atan_s2 <= atan2_pkg::FIX_PI_4, "octant angle beyond pi/4")

endmodule
